// ===== sv/quoted_printable_encoder_macros.svh =====
// ----------------------------------------------------------------------------
// quoted_printable_encoder_macros
// assertion shorthands shared by the encoder rtl, sampled on clk, off in reset
// ----------------------------------------------------------------------------
`ifndef QUOTED_PRINTABLE_ENCODER_MACROS_SVH
`define QUOTED_PRINTABLE_ENCODER_MACROS_SVH

// same-cycle implication
`define QPE_ASSERT_IMP(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("qpe assertion failed");

// next-cycle implication
`define QPE_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("qpe assertion failed");

`endif

// ===== sv/qpe_pkg.sv =====
// ----------------------------------------------------------------------------
// qpe_pkg
// constants and types of the quoted-printable encoder
// ----------------------------------------------------------------------------
package qpe_pkg;

    localparam logic [7:0] QPE_NUL  = 8'h00;
    localparam logic [7:0] QPE_LF   = 8'h0A;
    localparam logic [7:0] QPE_CR   = 8'h0D;
    localparam logic [7:0] QPE_EQ   = 8'h3D;
    localparam logic [7:0] QPE_HIGH = 8'h80;

    localparam logic QPE_REQ_DATA  = 1'b0;
    localparam logic QPE_REQ_FLUSH = 1'b1;

    localparam int QPE_MAX_OUT = 6;
    localparam int QPE_NUM_W   = 3;
    localparam int QPE_COL_W   = 7;

    localparam logic [QPE_COL_W-1:0] QPE_COL_MAX     = 7'd127;
    localparam logic [QPE_COL_W-1:0] QPE_LIMIT_RESET = 7'd72;

    typedef logic [QPE_MAX_OUT-1:0][7:0] qpe_bytes_t;
    typedef logic [QPE_NUM_W-1:0]        qpe_num_t;
    typedef logic [QPE_COL_W-1:0]        qpe_col_t;

    // result of encoding one held byte
    typedef struct packed {
        qpe_bytes_t bytes;
        qpe_num_t   num;
        qpe_col_t   column;
    } qpe_enc_t;

    function automatic logic [7:0] hex_digit(input logic [3:0] nib);
        return (nib < 4'd10) ? {4'h3, nib} : ({4'h0, nib} + 8'd55);
    endfunction

endpackage

// ===== sv/qpe_in_if.sv =====
// ----------------------------------------------------------------------------
// qpe_in_if
// input channel: request type and raw byte with valid/ready
// ----------------------------------------------------------------------------
interface qpe_in_if;
    logic       valid;
    logic       ready;
    logic       req_type;
    logic [7:0] data_byte;

    modport source (output valid, output req_type, output data_byte, input ready);
    modport sink   (input valid, input req_type, input data_byte, output ready);
endinterface

// ===== sv/qpe_out_if.sv =====
// ----------------------------------------------------------------------------
// qpe_out_if
// output channel: encoded character and last marker with valid/ready
// ----------------------------------------------------------------------------
interface qpe_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       last;

    modport source (output valid, output out_byte, output last, input ready);
    modport sink   (input valid, input out_byte, input last, output ready);
endinterface

// ===== sv/qpe_encoder.sv =====
// ----------------------------------------------------------------------------
// qpe_encoder
// combinational encode of the held byte given its lookahead and column count
// ----------------------------------------------------------------------------
module qpe_encoder
    import qpe_pkg::*;
(
    input  logic [7:0] held_byte,
    input  logic [7:0] lookahead,
    input  qpe_col_t   column,
    input  qpe_col_t   line_limit,
    output qpe_enc_t   result
);

    logic [2:0][7:0] body;
    qpe_num_t        body_num;
    logic            soft_brk;
    qpe_col_t        base;
    logic [7:0]      sum;
    qpe_col_t        col_next;

    always_comb
    begin
        body     = '0;
        body_num = '0;
        soft_brk = 1'b0;
        base     = column;
        sum      = '0;
        col_next = column;
        if (held_byte == QPE_NUL)
        begin
            body[0]  = QPE_NUL;
            body_num = 3'd1;
            col_next = '0;
        end
        else if (held_byte == QPE_LF || (held_byte == QPE_CR && lookahead != QPE_LF))
        begin
            body[0]  = QPE_CR;
            body[1]  = QPE_LF;
            body_num = 3'd2;
            col_next = '0;
        end
        else if (held_byte == QPE_CR)
        begin
            // cr of a cr lf pair: the lf carries the break
            body_num = '0;
        end
        else
        begin
            soft_brk = (column >= line_limit);
            base     = soft_brk ? '0 : column;
            if (held_byte >= QPE_HIGH || held_byte == QPE_EQ)
            begin
                body[0]  = QPE_EQ;
                body[1]  = hex_digit(held_byte[7:4]);
                body[2]  = hex_digit(held_byte[3:0]);
                body_num = 3'd3;
                sum      = {1'b0, base} + 8'd3;
            end
            else
            begin
                body[0]  = held_byte;
                body_num = 3'd1;
                sum      = {1'b0, base} + 8'd1;
            end
            col_next = (sum > {1'b0, QPE_COL_MAX}) ? QPE_COL_MAX : sum[QPE_COL_W-1:0];
        end
    end

    always_comb
    begin
        result.column = col_next;
        if (soft_brk)
        begin
            result.bytes = {body[2], body[1], body[0], QPE_LF, QPE_CR, QPE_EQ};
            result.num   = body_num + 3'd3;
        end
        else
        begin
            result.bytes = {24'h0, body[2], body[1], body[0]};
            result.num   = body_num;
        end
    end

endmodule

// ===== sv/quoted_printable_encoder.sv =====
// ----------------------------------------------------------------------------
// quoted_printable_encoder
// streaming quoted-printable encoder with one byte of lookahead
// ----------------------------------------------------------------------------
// Each data beat on stream is held until the next beat arrives, which serves
// as its lookahead; the held byte is then encoded into zero to six characters
// on encoded, the final one marked by last. A flush beat encodes the held byte
// against a zero lookahead and clears the line state. line_limit (reset 72)
// is to be written through cfg_we/cfg_wdata only while the block is idle; the
// block itself does not enforce this. Encoding is one pass of logic between
// the state registers and a staging register, so an input beat can be taken
// every cycle while staging is empty or moving to the buffer; the staging
// register and the output buffer decouple the two sides. The byte-wide port
// carries one character per output beat; an input beat makes 1 for a raw
// byte, 3 for an escaped one, and up to 6 with a soft break.
// ----------------------------------------------------------------------------
`include "quoted_printable_encoder_macros.svh"

module quoted_printable_encoder
    import qpe_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    qpe_in_if.sink           stream,
    qpe_out_if.source        encoded,
    input  logic             cfg_we,
    input  logic [6:0]       cfg_wdata
);

    // configuration
    qpe_col_t   limit_reg;

    // encoder state
    logic       byte_held_reg;
    logic [7:0] held_byte_reg;
    qpe_col_t   column_reg;

    // staging register between encoder and output buffer
    logic       stg_valid_reg;
    qpe_bytes_t stg_bytes_reg;
    qpe_num_t   stg_num_reg;

    // output buffer, drained one character a cycle while encoded is ready
    logic       obuf_valid_reg;
    qpe_bytes_t obuf_bytes_reg;
    qpe_num_t   obuf_num_reg;
    qpe_num_t   obuf_idx_reg;
    qpe_num_t   obuf_idx_next;

    logic       accept;
    logic       beat;
    logic       out_last;
    logic       take;
    logic       load;
    logic       is_flush;
    logic [7:0] lookahead;
    qpe_enc_t   enc;
    qpe_num_t   enc_num;

    assign is_flush  = (stream.req_type == QPE_REQ_FLUSH);
    // a flush encodes against a zero lookahead; its byte field is ignored
    assign lookahead = is_flush ? QPE_NUL : stream.data_byte;

    qpe_encoder u_encoder (
        .held_byte  (held_byte_reg),
        .lookahead  (lookahead),
        .column     (column_reg),
        .line_limit (limit_reg),
        .result     (enc)
    );

    // nothing is emitted when no byte is waiting
    assign enc_num = byte_held_reg ? enc.num : '0;

    // output side handshake
    assign beat     = encoded.valid && encoded.ready;
    assign out_last = (obuf_idx_reg == (obuf_num_reg - 3'd1));
    // staging moves to the buffer when the buffer is empty or finishing
    assign take     = stg_valid_reg && (!obuf_valid_reg || (beat && out_last));

    // input side: room when staging is empty or moving on this cycle
    assign stream.ready = !stg_valid_reg || take;
    assign accept       = stream.valid && stream.ready;
    assign load         = accept && (enc_num != '0);

    assign encoded.valid    = obuf_valid_reg;
    assign encoded.out_byte = obuf_bytes_reg[obuf_idx_reg];
    assign encoded.last     = out_last;

    // line limit register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg <= QPE_LIMIT_RESET;
        end
        else if (cfg_we)
        begin
            limit_reg <= cfg_wdata;
        end
    end

    // lookahead and column state, advanced on every accepted beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_held_reg <= 1'b0;
            held_byte_reg <= '0;
            column_reg    <= '0;
        end
        else if (accept)
        begin
            if (is_flush)
            begin
                byte_held_reg <= 1'b0;
                held_byte_reg <= '0;
                column_reg    <= '0;
            end
            else
            begin
                byte_held_reg <= 1'b1;
                held_byte_reg <= stream.data_byte;
                if (byte_held_reg)
                begin
                    column_reg <= enc.column;
                end
            end
        end
    end

    // staging control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stg_valid_reg <= 1'b0;
        end
        else if (load)
        begin
            stg_valid_reg <= 1'b1;
        end
        else if (take)
        begin
            stg_valid_reg <= 1'b0;
        end
    end

    // staging payload
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            stg_bytes_reg <= enc.bytes;
            stg_num_reg   <= enc_num;
        end
    end

    // output buffer index
    always_comb
    begin
        obuf_idx_next = obuf_idx_reg;
        if (take)
        begin
            obuf_idx_next = '0;
        end
        else if (beat && !out_last)
        begin
            obuf_idx_next = obuf_idx_reg + 3'd1;
        end
    end

    // output buffer control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            obuf_valid_reg <= 1'b0;
            obuf_idx_reg   <= '0;
        end
        else
        begin
            obuf_idx_reg <= obuf_idx_next;
            if (take)
            begin
                obuf_valid_reg <= 1'b1;
            end
            else if (beat && out_last)
            begin
                obuf_valid_reg <= 1'b0;
            end
        end
    end

    // output buffer payload
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            obuf_bytes_reg <= stg_bytes_reg;
            obuf_num_reg   <= stg_num_reg;
        end
    end

    // the read index stays inside the loaded sequence
    `QPE_ASSERT_IMP(a_idx_in_range, obuf_valid_reg, obuf_idx_reg < obuf_num_reg)
    // a loaded sequence is never empty nor longer than six characters
    `QPE_ASSERT_IMP(a_num_bound, obuf_valid_reg, (obuf_num_reg != '0) && (obuf_num_reg <= 3'd6))
    // a staged sequence waits until the buffer takes it
    `QPE_ASSERT_NEXT(a_stage_kept, stg_valid_reg && !take, stg_valid_reg)
    // a non-final beat steps to the next character
    `QPE_ASSERT_NEXT(a_idx_step, beat && !out_last, obuf_idx_reg == ($past(obuf_idx_reg) + 3'd1))

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the quoted-printable encoder: a directed table,
// then random text lines under several line limits, with random stalls on
// both channels and one long hold-off on the encoded side
// ----------------------------------------------------------------------------
module tb_top;
    import qpe_pkg::*;

    // no input beat or output beat for this many cycles means the run is stuck
    localparam int WATCHDOG_LIMIT = 2000;
    // cycles allowed for a beat that makes no characters to clear the block
    localparam int DRAIN_CYCLES   = 16;
    // length of the long hold-off on the encoded side
    localparam int HOLD_CYCLES    = 150;
    localparam int NUM_PHASES     = 6;

    // line limit and beat count of each random phase; the fifth limit is random
    localparam int PHASE_LIMIT [NUM_PHASES] = '{76, 4, 53, 75, 0, 72};
    localparam int PHASE_BEATS [NUM_PHASES] = '{60, 40, 40, 40, 30, 30};

    typedef enum logic [0:0] {
        ROW_BEAT,
        ROW_LIMIT
    } row_kind_t;

    // one row of the directed table; num_chars < 0 means use the predictor,
    // otherwise chars holds the expected characters, first one in the highest used byte
    typedef struct packed {
        row_kind_t   kind;
        logic        req;
        logic [7:0]  value;
        int          num_chars;
        logic [47:0] chars;
    } dir_row_t;

    localparam int NUM_ROWS = 27;

    localparam dir_row_t DIR_PLAN [NUM_ROWS] = '{
        // line limit at its reset value of 72
        '{ROW_BEAT,  QPE_REQ_DATA,  8'h41, 0, 48'h0},           // first byte is only held
        '{ROW_BEAT,  QPE_REQ_DATA,  8'h00, 1, 48'h41},          // raw 'A'
        '{ROW_BEAT,  QPE_REQ_DATA,  8'hFF, 1, 48'h00},          // nul passes through
        '{ROW_BEAT,  QPE_REQ_DATA,  QPE_EQ, 3, 48'h3D4646},     // 0xff escaped
        '{ROW_BEAT,  QPE_REQ_DATA,  QPE_CR, 3, 48'h3D3344},     // '=' escaped
        '{ROW_BEAT,  QPE_REQ_DATA,  QPE_LF, 0, 48'h0},          // cr before lf dropped
        '{ROW_BEAT,  QPE_REQ_DATA,  QPE_CR, 2, 48'h0D0A},       // lf becomes cr lf
        '{ROW_BEAT,  QPE_REQ_DATA,  8'h78, 2, 48'h0D0A},        // lone cr becomes cr lf
        '{ROW_BEAT,  QPE_REQ_DATA,  QPE_HIGH, 1, 48'h78},       // raw 'x'
        '{ROW_BEAT,  QPE_REQ_DATA,  8'h7F, 3, 48'h3D3830},      // 0x80 escaped
        '{ROW_BEAT,  QPE_REQ_FLUSH, 8'hFF, 1, 48'h7F},          // flush ignores its byte
        '{ROW_BEAT,  QPE_REQ_FLUSH, 8'h00, 0, 48'h0},           // flush with nothing held
        '{ROW_BEAT,  QPE_REQ_DATA,  QPE_CR, 0, 48'h0},
        '{ROW_BEAT,  QPE_REQ_FLUSH, 8'h55, 2, 48'h0D0A},        // cr against zero lookahead
        // smallest line limit, soft breaks
        '{ROW_LIMIT, QPE_REQ_DATA,  8'd4, 0, 48'h0},
        '{ROW_BEAT,  QPE_REQ_DATA,  8'h61, 0, 48'h0},
        '{ROW_BEAT,  QPE_REQ_DATA,  8'h62, 1, 48'h61},
        '{ROW_BEAT,  QPE_REQ_DATA,  8'h63, 1, 48'h62},
        '{ROW_BEAT,  QPE_REQ_DATA,  8'h64, 1, 48'h63},
        '{ROW_BEAT,  QPE_REQ_DATA,  8'h65, 1, 48'h64},
        '{ROW_BEAT,  QPE_REQ_DATA,  8'h66, 4, 48'h3D0D0A65},    // soft break, then 'e'
        '{ROW_BEAT,  QPE_REQ_DATA,  8'hC3, 1, 48'h66},
        '{ROW_BEAT,  QPE_REQ_DATA,  8'hE9, 3, 48'h3D4333},
        '{ROW_BEAT,  QPE_REQ_FLUSH, 8'h00, 6, 48'h3D0D0A3D4539}, // soft break plus escape
        '{ROW_BEAT,  QPE_REQ_DATA,  8'h01, -1, 48'h0},
        '{ROW_BEAT,  QPE_REQ_DATA,  8'hFE, -1, 48'h0},
        '{ROW_BEAT,  QPE_REQ_FLUSH, 8'h00, -1, 48'h0}
    };

    logic       clk;
    logic       rst_n;
    logic       cfg_we;
    logic [6:0] cfg_wdata;

    qpe_in_if  in_ch ();
    qpe_out_if out_ch ();

    quoted_printable_encoder dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .stream    (in_ch),
        .encoded   (out_ch),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    // ------------------------------------------------------------------------
    // encoder state as the bench sees it
    // ------------------------------------------------------------------------
    logic       pend_valid = 1'b0;       // a byte is waiting for its lookahead
    logic [7:0] pend_char  = QPE_NUL;
    qpe_col_t   line_col   = '0;         // characters on the current line
    qpe_col_t   col_limit  = QPE_LIMIT_RESET;

    logic [7:0] beat_chars [$];          // characters made by the latest beat
    logic [7:0] exp_chars  [$];          // characters still owed by the block
    logic       exp_lasts  [$];

    int  mismatches  = 0;
    int  beats_sent  = 0;
    int  idle_cycles = 0;
    bit  gaps_on     = 1'b1;
    bit  stalls_on   = 1'b1;
    bit  hold_off    = 1'b0;             // long hold-off requested

    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        return (nib < 4'd10) ? 8'd48 + 8'(nib) : 8'd55 + 8'(nib);
    endfunction

    function automatic void bump_col(input int amount);
        int sum;
        sum = int'(line_col) + amount;
        line_col = (sum > int'(QPE_COL_MAX)) ? QPE_COL_MAX : qpe_col_t'(sum);
    endfunction

    // encode the waiting byte, with la as the byte after it
    function automatic void encode_pending(input logic [7:0] la);
        if (pend_char == QPE_NUL)
        begin
            beat_chars.push_back(QPE_NUL);
            line_col = '0;
        end
        else if (pend_char == QPE_LF || (pend_char == QPE_CR && la != QPE_LF))
        begin
            beat_chars.push_back(QPE_CR);
            beat_chars.push_back(QPE_LF);
            line_col = '0;
        end
        else if (pend_char != QPE_CR)
        begin
            // soft break once the line is full
            if (line_col >= col_limit)
            begin
                beat_chars.push_back(QPE_EQ);
                beat_chars.push_back(QPE_CR);
                beat_chars.push_back(QPE_LF);
                line_col = '0;
            end
            if (pend_char >= QPE_HIGH || pend_char == QPE_EQ)
            begin
                beat_chars.push_back(QPE_EQ);
                beat_chars.push_back(hex_char(pend_char[7:4]));
                beat_chars.push_back(hex_char(pend_char[3:0]));
                bump_col(3);
            end
            else
            begin
                beat_chars.push_back(pend_char);
                bump_col(1);
            end
        end
    endfunction

    // characters that one accepted input beat makes, state updated
    function automatic void encode_beat(input logic req, input logic [7:0] value);
        beat_chars.delete();
        if (req == QPE_REQ_DATA)
        begin
            if (pend_valid)
                encode_pending(value);
            pend_char  = value;
            pend_valid = 1'b1;
        end
        else
        begin
            if (pend_valid)
                encode_pending(QPE_NUL);
            pend_valid = 1'b0;
            pend_char  = QPE_NUL;
            line_col   = '0;
        end
    endfunction

    // ------------------------------------------------------------------------
    // clock and reset
    // ------------------------------------------------------------------------
    initial clk = 1'b0;
    always #2 clk = ~clk;

    // ------------------------------------------------------------------------
    // input side
    // ------------------------------------------------------------------------

    // offer one beat, wait for it to be taken, then queue what it should make;
    // typed_n < 0 takes the prediction, otherwise the typed characters
    task automatic send_beat(input logic req, input logic [7:0] value,
                             input int typed_n, input logic [47:0] typed_chars);
        int i;
        if (gaps_on && $urandom_range(0, 3) == 0)
        begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.req_type  <= req;
        in_ch.data_byte <= value;
        do
            @(posedge clk);
        while (in_ch.ready !== 1'b1);
        beats_sent++;
        encode_beat(req, value);
        if (typed_n >= 0)
        begin
            beat_chars.delete();
            for (i = 0; i < typed_n; i++)
                beat_chars.push_back(typed_chars[8 * (typed_n - 1 - i) +: 8]);
        end
        foreach (beat_chars[k])
        begin
            exp_chars.push_back(beat_chars[k]);
            exp_lasts.push_back(k == beat_chars.size() - 1);
        end
    endtask

    // line limit change, only with the block idle
    task automatic write_limit(input logic [6:0] value);
        in_ch.valid <= 1'b0;
        while (exp_chars.size() != 0)
            @(posedge clk);
        // a beat that makes no characters may still be inside
        repeat (DRAIN_CYCLES) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        col_limit = value;
    endtask

    // mostly printable text, some escapes, some anything
    function automatic logic [7:0] pick_text();
        int k;
        k = $urandom_range(0, 99);
        if (k < 70)
            return 8'($urandom_range(8'h20, 8'h7E));
        else if (k < 85)
            return 8'($urandom_range(8'h80, 8'hFF));
        else if (k < 92)
            return QPE_EQ;
        else
            return 8'($urandom_range(0, 255));
    endfunction

    // a run of text, no longer than room, usually closed by one of the line endings,
    // now and then followed by a few beats of noise
    task automatic send_line(input bit long_line, input int room);
        int len;
        int ending;
        len    = long_line ? $urandom_range(60, 110) : $urandom_range(1, 20);
        ending = $urandom_range(0, 5);
        if (len > room)
            len = room;
        repeat (len) send_beat(QPE_REQ_DATA, pick_text(), -1, '0);
        if (ending == 0)
        begin
            send_beat(QPE_REQ_DATA, QPE_CR, -1, '0);
            send_beat(QPE_REQ_DATA, QPE_LF, -1, '0);
        end
        else if (ending == 1)
            send_beat(QPE_REQ_DATA, QPE_LF, -1, '0);
        else if (ending == 2)
            send_beat(QPE_REQ_DATA, QPE_CR, -1, '0);
        else if (ending == 3)
            send_beat(QPE_REQ_DATA, QPE_NUL, -1, '0);
        else if (ending == 4)
            send_beat(QPE_REQ_FLUSH, 8'($urandom_range(0, 255)), -1, '0);
        // otherwise the line runs on into the next one
        if ($urandom_range(0, 9) == 0)
            repeat ($urandom_range(1, 4))
                send_beat(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)), -1, '0);
    endtask

    initial
    begin : stimulus
        int p;
        int r;
        int first_beat;
        logic [6:0] limit_val;

        rst_n           <= 1'b0;
        cfg_we          <= 1'b0;
        cfg_wdata       <= '0;
        in_ch.valid     <= 1'b0;
        in_ch.req_type  <= QPE_REQ_DATA;
        in_ch.data_byte <= QPE_NUL;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table
        for (r = 0; r < NUM_ROWS; r++)
        begin
            if (DIR_PLAN[r].kind == ROW_LIMIT)
                write_limit(DIR_PLAN[r].value[6:0]);
            else
                send_beat(DIR_PLAN[r].req, DIR_PLAN[r].value,
                          DIR_PLAN[r].num_chars, DIR_PLAN[r].chars);
        end

        // random phases, each under its own line limit
        for (p = 0; p < NUM_PHASES; p++)
        begin
            if (p == NUM_PHASES - 1)
            begin
                // last stretch runs with no idling on either side
                gaps_on   = 1'b0;
                stalls_on = 1'b0;
            end
            limit_val = (PHASE_LIMIT[p] == 0) ? 7'($urandom_range(4, 76))
                                              : 7'(PHASE_LIMIT[p]);
            write_limit(limit_val);
            // long hold-off on the encoded side while input keeps coming
            if (p == 1)
                hold_off = 1'b1;
            first_beat = beats_sent;
            while (beats_sent - first_beat < PHASE_BEATS[p])
                send_line(p == 0 || $urandom_range(0, 3) == 0,
                          PHASE_BEATS[p] - (beats_sent - first_beat));
            send_beat(QPE_REQ_FLUSH, 8'($urandom_range(0, 255)), -1, '0);
        end

        in_ch.valid <= 1'b0;
        while (exp_chars.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("PASS quoted_printable_encoder");
        else
            $display("FAIL quoted_printable_encoder");
        $finish;
    end

    // ------------------------------------------------------------------------
    // encoded side: ready with random stalls and one long hold-off
    // ------------------------------------------------------------------------
    initial
    begin : receiver
        bit hold_done;
        hold_done = 1'b0;
        out_ch.ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (hold_off && !hold_done)
            begin
                out_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_done = 1'b1;
            end
            else if (stalls_on && $urandom_range(0, 4) == 0)
            begin
                out_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge clk);
            end
            else
            begin
                out_ch.ready <= 1'b1;
                repeat ($urandom_range(1, 20)) @(posedge clk);
            end
        end
    end

    // ------------------------------------------------------------------------
    // check every encoded beat against the oldest owed character, and
    // watch for a stuck run
    // ------------------------------------------------------------------------
    logic [7:0] want_char;
    logic       want_last;

    always @(posedge clk)
    begin
        if (rst_n === 1'b1)
        begin
            if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1)
            begin
                if (exp_chars.size() == 0)
                begin
                    $display("%0t: unexpected beat, expected none, actual out_byte %h last %b",
                             $time, out_ch.out_byte, out_ch.last);
                    mismatches++;
                end
                else
                begin
                    want_char = exp_chars.pop_front();
                    want_last = exp_lasts.pop_front();
                    if (out_ch.out_byte !== want_char)
                    begin
                        $display("%0t: out_byte mismatch, expected %h actual %h",
                                 $time, want_char, out_ch.out_byte);
                        mismatches++;
                    end
                    if (out_ch.last !== want_last)
                    begin
                        $display("%0t: last mismatch, expected %b actual %b",
                                 $time, want_last, out_ch.last);
                        mismatches++;
                    end
                end
            end

            if ((out_ch.valid === 1'b1 && out_ch.ready === 1'b1) ||
                (in_ch.valid === 1'b1 && in_ch.ready === 1'b1))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("%0t: timeout, no beat for %0d cycles", $time, idle_cycles);
                $display("FAIL quoted_printable_encoder");
                $finish;
            end
        end
    end

endmodule

// ===== filelist.f =====
+incdir+sv
sv/qpe_pkg.sv
sv/qpe_in_if.sv
sv/qpe_out_if.sv
sv/qpe_encoder.sv
sv/quoted_printable_encoder.sv
tb/tb_top.sv
